/* hdl/gsb_pkg.sv */
package gsb_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    localparam logic [2:0] KIND_LOAD   = 3'd0;
    localparam logic [2:0] KIND_CURSOR = 3'd1;
    localparam logic [2:0] KIND_TEXT   = 3'd2;
    localparam logic [2:0] KIND_DIGIT  = 3'd3;
    localparam logic [2:0] KIND_GLYPH  = 3'd4;

    localparam logic [1:0] CFG_FB_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_FB_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_GLYPH_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd3;

    localparam logic [7:0]  TEXT_FIRST = 8'd32;
    localparam logic [7:0]  TEXT_END   = 8'd97;
    localparam logic [7:0]  DIGIT_MAX  = 8'd9;
    localparam logic [10:0] FB_LIMIT   = 11'd1024;
    localparam logic [10:0] CURSOR_MAX = 11'd2047;

    localparam logic [10:0] FB_WIDTH_RST     = 11'd224;
    localparam logic [10:0] FB_HEIGHT_RST    = 11'd256;
    localparam logic [3:0]  GLYPH_WIDTH_RST  = 4'd5;
    localparam logic [3:0]  GLYPH_HEIGHT_RST = 4'd7;

    typedef struct packed {
        logic clear;
        logic idle;
        logic fetch;
        logic scan;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic draw_start;
        logic fetch_done;
        logic scan_last;
        logic scan_stall;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

/* hdl/gsb_ctrl.sv */
module gsb_ctrl
    import gsb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (sts.draw_start)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (sts.fetch_done)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_last && !sts.scan_stall)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (!sts.pend_valid || sts.out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear = 1'b1;
            ST_IDLE:  cmd.idle  = 1'b1;
            ST_FETCH: cmd.fetch = 1'b1;
            ST_SCAN:  cmd.scan  = 1'b1;
            ST_FLUSH: cmd.flush = 1'b1;
        endcase
    end

endmodule

/* hdl/gsb_datapath.sv */
module gsb_datapath
    import gsb_pkg::*;
#(
    parameter int GLYPH_SLOTS    = 128,
    parameter int MAX_GLYPH_SIDE = 8,
    parameter int DIGIT_BASE     = 65
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    input  logic [2:0]  kind,
    input  logic [7:0]  code,
    input  logic [2:0]  glyph_row,
    input  logic [7:0]  row_bits,
    input  logic [9:0]  x_pos,
    input  logic [9:0]  y_pos,
    input  logic [31:0] paint,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  pixel_col,
    output logic [9:0]  pixel_row,
    output logic [19:0] pixel_address,
    output logic [31:0] pixel_color,
    output logic        last_write
);

    localparam int MEM_DEPTH = GLYPH_SLOTS * MAX_GLYPH_SIDE;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int RW = (MAX_GLYPH_SIDE > 1) ? $clog2(MAX_GLYPH_SIDE) : 1;
    localparam int CW = $clog2(MAX_GLYPH_SIDE + 1);
    localparam logic [CW-1:0] SIDE_MAX = CW'(MAX_GLYPH_SIDE);

    // config and cursor
    logic [10:0] fb_width_reg;
    logic [10:0] fb_height_reg;
    logic [3:0]  glyph_width_reg;
    logic [3:0]  glyph_height_reg;
    logic [10:0] cursor_x_reg;
    logic [9:0]  cursor_y_reg;
    logic [31:0] cursor_color_reg;

    // glyph store
    logic [7:0]    mem [MEM_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] clear_cnt_reg;

    // draw context
    logic [AW-1:0] base_reg;
    logic [10:0]   x_reg;
    logic [9:0]    y_reg;
    logic [31:0]   color_reg;
    logic [7:0]    rows_reg [2**RW];
    logic [CW-1:0] fcnt_reg;
    logic [CW-1:0] sx_reg;
    logic [CW-1:0] sy_reg;

    // pending write and output stage
    logic        pend_valid_reg;
    logic [9:0]  pend_col_reg;
    logic [9:0]  pend_row_reg;
    logic [19:0] pend_addr_reg;
    logic        out_valid_reg;
    logic [9:0]  out_col_reg;
    logic [9:0]  out_row_reg;
    logic [19:0] out_addr_reg;
    logic [31:0] out_color_reg;
    logic        out_last_reg;

    logic [CW-1:0] gw;
    logic [CW-1:0] gh;
    logic [10:0]   bw;
    logic [10:0]   bh;
    logic          accept;
    logic [7:0]    glyph_sel;
    logic          cursor_draw;
    logic          any_draw;
    logic          slot_ok;
    logic          draw_start;
    logic [11:0]   cursor_nx;
    logic [CW-1:0] fcnt_m1;
    logic [7:0]    row_sel;
    logic [7:0]    row_shift;
    logic [11:0]   col_c;
    logic [10:0]   row_c;
    logic [CW-1:0] row_off;
    logic [20:0]   addr_prod;
    logic [19:0]   addr_c;
    logic          hit;
    logic          scan_go;
    logic          out_free;
    logic          push_mid;
    logic          push_last;

    assign gw = (glyph_width_reg > 4'(MAX_GLYPH_SIDE)) ? SIDE_MAX : CW'(glyph_width_reg);
    assign gh = (glyph_height_reg > 4'(MAX_GLYPH_SIDE)) ? SIDE_MAX : CW'(glyph_height_reg);
    assign bw = (fb_width_reg > FB_LIMIT) ? FB_LIMIT : fb_width_reg;
    assign bh = (fb_height_reg > FB_LIMIT) ? FB_LIMIT : fb_height_reg;

    assign accept = cmd.idle && in_valid;

    always_comb
    begin
        glyph_sel   = code;
        cursor_draw = 1'b0;
        any_draw    = 1'b0;
        unique case (kind)
            KIND_TEXT:
            begin
                glyph_sel   = code - TEXT_FIRST;
                cursor_draw = (code >= TEXT_FIRST) && (code < TEXT_END);
                any_draw    = cursor_draw;
            end
            KIND_DIGIT:
            begin
                glyph_sel   = 8'(DIGIT_BASE) + code;
                cursor_draw = (code <= DIGIT_MAX);
                any_draw    = cursor_draw;
            end
            KIND_GLYPH:
            begin
                any_draw = 1'b1;
            end
            default:
            begin
                any_draw = 1'b0;
            end
        endcase
    end

    assign slot_ok    = {1'b0, glyph_sel} < 9'(GLYPH_SLOTS);
    assign draw_start = in_valid && any_draw && slot_ok && (gw != '0) && (gh != '0);
    assign cursor_nx  = 12'(cursor_x_reg) + 12'(gw) + 12'd1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg     <= FB_WIDTH_RST;
            fb_height_reg    <= FB_HEIGHT_RST;
            glyph_width_reg  <= GLYPH_WIDTH_RST;
            glyph_height_reg <= GLYPH_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FB_WIDTH:     fb_width_reg     <= cfg_data;
                CFG_FB_HEIGHT:    fb_height_reg    <= cfg_data;
                CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[3:0];
                CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[3:0];
            endcase
        end
    end

    // cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            cursor_color_reg <= '0;
        end
        else if (accept)
        begin
            if (kind == KIND_CURSOR)
            begin
                cursor_x_reg     <= {1'b0, x_pos};
                cursor_y_reg     <= y_pos;
                cursor_color_reg <= paint;
            end
            else if (cursor_draw)
            begin
                cursor_x_reg <= (cursor_nx > 12'(CURSOR_MAX)) ? CURSOR_MAX : cursor_nx[10:0];
            end
        end
    end

    // glyph store: clearing pass after reset, row loads, one read port
    assign mem_we = cmd.clear
                  || (accept && (kind == KIND_LOAD) && ({1'b0, code} < 9'(GLYPH_SLOTS))
                      && ({1'b0, glyph_row} < 4'(MAX_GLYPH_SIDE)));
    assign mem_waddr = cmd.clear ? clear_cnt_reg
                                 : AW'(32'(code) * MAX_GLYPH_SIDE + 32'(glyph_row));
    assign mem_wdata = cmd.clear ? 8'd0 : row_bits;
    assign mem_raddr = base_reg + AW'(fcnt_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_cnt_reg <= '0;
        else if (cmd.clear)
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
    end

    // draw context
    always_ff @(posedge clk)
    begin
        if (accept && draw_start)
        begin
            base_reg <= AW'(32'(glyph_sel) * MAX_GLYPH_SIDE);
            if (kind == KIND_GLYPH)
            begin
                x_reg     <= {1'b0, x_pos};
                y_reg     <= y_pos;
                color_reg <= paint;
            end
            else
            begin
                x_reg     <= cursor_x_reg;
                y_reg     <= cursor_y_reg;
                color_reg <= cursor_color_reg;
            end
        end
    end

    // row fetch: read data lands in the cycle after the address
    assign fcnt_m1 = fcnt_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.fetch && (fcnt_reg != '0))
            rows_reg[fcnt_m1[RW-1:0]] <= rd_data_reg;
    end

    // pixel scan, columns outer, glyph rows inner
    assign row_sel   = rows_reg[sy_reg[RW-1:0]];
    assign row_shift = row_sel >> sx_reg;
    assign col_c     = 12'(x_reg) + 12'(sx_reg);
    assign row_off   = gh - CW'(1) - sy_reg;
    assign row_c     = 11'(y_reg) + 11'(row_off);
    assign hit       = row_shift[0] && (row_c < bh) && (col_c < 12'(bw));
    assign addr_prod = 21'(row_c[9:0]) * 21'(bw);
    assign addr_c    = 20'(addr_prod + 21'(col_c[9:0]));

    assign out_free  = !out_valid_reg || out_ready;
    assign scan_go   = cmd.scan && !(hit && pend_valid_reg && !out_free);
    assign push_mid  = scan_go && hit && pend_valid_reg;
    assign push_last = cmd.flush && pend_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
        end
        else if (accept)
        begin
            fcnt_reg <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
        end
        else
        begin
            if (cmd.fetch)
                fcnt_reg <= fcnt_reg + 1'b1;
            if (scan_go)
            begin
                if (sy_reg == gh - CW'(1))
                begin
                    sy_reg <= '0;
                    sx_reg <= sx_reg + 1'b1;
                end
                else
                begin
                    sy_reg <= sy_reg + 1'b1;
                end
            end
        end
    end

    // one write held back so the final one can be marked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (scan_go && hit)
            pend_valid_reg <= 1'b1;
        else if (push_last)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (scan_go && hit)
        begin
            pend_col_reg  <= col_c[9:0];
            pend_row_reg  <= row_c[9:0];
            pend_addr_reg <= addr_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push_mid || push_last)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push_mid || push_last)
        begin
            out_col_reg   <= pend_col_reg;
            out_row_reg   <= pend_row_reg;
            out_addr_reg  <= pend_addr_reg;
            out_color_reg <= color_reg;
            out_last_reg  <= push_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_col     = out_col_reg;
    assign pixel_row     = out_row_reg;
    assign pixel_address = out_addr_reg;
    assign pixel_color   = out_color_reg;
    assign last_write    = out_last_reg;

    always_comb
    begin
        sts            = '0;
        sts.clear_done = (clear_cnt_reg == AW'(MEM_DEPTH - 1));
        sts.draw_start = draw_start;
        sts.fetch_done = (fcnt_reg == gh);
        sts.scan_last  = (sx_reg == gw - CW'(1)) && (sy_reg == gh - CW'(1));
        sts.scan_stall = cmd.scan && !scan_go;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

endmodule

/* hdl/glyph_sprite_blitter_core.sv */
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------------------
// input     | in_valid / in_ready   | kind code glyph_row row_bits x_pos y_pos paint
// output    | out_valid / out_ready | pixel_col pixel_row pixel_address pixel_color
//           |                       | last_write
// config    | cfg_we (no wait)      | cfg_index cfg_data
//
// Load, cursor and non-drawing items are taken in the idle state and leave it idle.
// Draw items: h row reads from the one read port of the glyph store, then one
// glyph pixel per cycle unless the scan is stalled, w and h the glyph size.
// After reset a clearing pass zeroes all GLYPH_SLOTS*MAX_GLYPH_SIDE rows of the
// glyph store; in_ready stays low meanwhile.
// Output back-pressure stalls the pixel scan only when a second write is ready.
module glyph_sprite_blitter_core
    import gsb_pkg::*;
#(
    parameter int GLYPH_SLOTS    = 128,
    parameter int MAX_GLYPH_SIDE = 8,
    parameter int DIGIT_BASE     = 65
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [7:0]  code,
    input  logic [2:0]  glyph_row,
    input  logic [7:0]  row_bits,
    input  logic [9:0]  x_pos,
    input  logic [9:0]  y_pos,
    input  logic [31:0] paint,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  pixel_col,
    output logic [9:0]  pixel_row,
    output logic [19:0] pixel_address,
    output logic [31:0] pixel_color,
    output logic        last_write
);

    cmd_t cmd;
    sts_t sts;

    gsb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    gsb_datapath #(
        .GLYPH_SLOTS    (GLYPH_SLOTS),
        .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE),
        .DIGIT_BASE     (DIGIT_BASE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .kind          (kind),
        .code          (code),
        .glyph_row     (glyph_row),
        .row_bits      (row_bits),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .paint         (paint),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_col     (pixel_col),
        .pixel_row     (pixel_row),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_write    (last_write)
    );

    assign in_ready = cmd.idle;

endmodule

/* hdl/gsb_checker.sv */
module gsb_checker
    import gsb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  pixel_col,
    input logic [9:0]  pixel_row,
    input logic [19:0] pixel_address,
    input logic [31:0] pixel_color,
    input logic        last_write
);

    // stalled write holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_col) && $stable(pixel_row)
            && $stable(pixel_address) && $stable(pixel_color) && $stable(last_write))
        else $error("stalled pixel write changed");

    // loads and cursor moves never leave the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_LOAD || kind == KIND_CURSOR) |=> in_ready)
        else $error("non-drawing transfer left the block busy");

    // nothing appears while idle with no draw in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid && !out_valid |=> !out_valid)
        else $error("pixel write appeared while idle");

    // a non-final write means its draw is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_write |-> !in_ready)
        else $error("new item taken before the draw finished");

endmodule

bind glyph_sprite_blitter_core gsb_checker u_gsb_checker (.*);
